FILE: hw/rtl/xsug_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsug_pkg
// Shared types, constants and helpers for the xorshift64 uniform generator.
// ----------------------------------------------------------------------------
package xsug_pkg;

  localparam int unsigned DataW     = 64;
  localparam int unsigned FracShift = 12;
  localparam int unsigned MaxDraws  = 4096;
  localparam int unsigned DrawCntW  = $clog2(MaxDraws + 1);
  localparam int unsigned RemCntW   = $clog2(DataW + 1);

  localparam logic [DataW-1:0] SeedReset = DataW'(1);

  typedef enum logic [1:0] {
    REQ_RAW      = 2'd0,
    REQ_UNIFORM  = 2'd1,
    REQ_RANGE    = 2'd2,
    REQ_FRACTION = 2'd3
  } req_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LIMIT,
    ST_DRAW,
    ST_CHECK,
    ST_FINAL,
    ST_RESP
  } gen_state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } rem_req_t;

  function automatic logic [DataW-1:0] xs_next(input logic [DataW-1:0] s);
    logic [DataW-1:0] t;
    t = s ^ (s << 21);
    t = t ^ (t >> 15);
    t = t ^ (t << 29);
    return t;
  endfunction

endpackage

FILE: hw/rtl/xsug_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsug_if
// Valid/ready channels: request, response and seed write.
// ----------------------------------------------------------------------------
interface xsug_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [63:0]        upper_bound;
  logic signed [63:0] range_low;
  logic signed [63:0] range_high;

  modport source (output valid, req_type, upper_bound, range_low, range_high,
                  input ready);
  modport sink (input valid, req_type, upper_bound, range_low, range_high,
                output ready);
endinterface

interface xsug_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        bad_bound;

  modport source (output valid, value, bad_bound, input ready);
  modport sink (input valid, value, bad_bound, output ready);
endinterface

interface xsug_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

FILE: hw/rtl/xsug_remu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsug_remu
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module xsug_remu
  import xsug_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rem_req_t         req_i,
  output logic             done_o,
  output logic [DataW-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0]   dvd_q, dvd_d;
  logic [DataW-1:0]   dvs_q, dvs_d;
  logic [DataW-1:0]   rem_q, rem_d;
  logic [DataW:0]     trial;
  logic [DataW:0]     diff;

  always_comb begin
    trial  = {rem_q, dvd_q[DataW-1]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = RemCntW'(DataW);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - RemCntW'(1);
      if (cnt_q == RemCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/xorshift64_uniform_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift64_uniform_generator
// Xorshift64 generator with raw, bounded, range and Q0.52 fraction draws.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    beat
//  cfg_i    in   seed                                       loads state
//  req_i    in   req_type, upper_bound, range_low/high      one request
//  rsp_o    out  value, bad_bound                           one result
//
//  Path from request beat to result beat: raw/fraction go straight to the
//  result; a bad bound passes ST_SETUP (state untouched); uniform/range pass
//  ST_SETUP, ST_LIMIT, ST_DRAW/ST_CHECK per draw and ST_FINAL; both modulo
//  steps run through one bit-serial remainder unit. Reset loads state 1. One
//  request in flight; req_i.ready is low until the result beat is taken.
// ----------------------------------------------------------------------------
module xorshift64_uniform_generator
  import xsug_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  xsug_cfg_if.sink   cfg_i,
  xsug_req_if.sink   req_i,
  xsug_rsp_if.source rsp_o
);

  gen_state_e          st_q, st_d;
  logic [DataW-1:0]    gen_q, gen_d;
  logic [DataW-1:0]    bound_q, bound_d;
  logic [DataW-1:0]    ofs_q, ofs_d;
  logic [DataW-1:0]    limit_q, limit_d;
  logic [DataW-1:0]    x_q, x_d;
  logic [DataW-1:0]    val_q, val_d;
  logic                bad_q, bad_d;
  logic [DrawCntW-1:0] n_q, n_d;
  logic [DataW-1:0]    gen_nxt;
  logic                req_fire;
  req_kind_e           kind;
  rem_req_t            rem_req;
  logic                rem_done;
  logic [DataW-1:0]    rem;

  xsug_remu u_remu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem)
  );

  assign cfg_i.ready  = 1'b1;
  assign req_i.ready  = (st_q == ST_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign kind         = req_kind_e'(req_i.req_type);
  assign gen_nxt      = xs_next(gen_q);
  assign rsp_o.valid     = (st_q == ST_RESP);
  assign rsp_o.value     = val_q;
  assign rsp_o.bad_bound = bad_q;

  always_comb begin
    st_d    = st_q;
    gen_d   = gen_q;
    bound_d = bound_q;
    ofs_d   = ofs_q;
    limit_d = limit_q;
    x_d     = x_q;
    val_d   = val_q;
    bad_d   = bad_q;
    n_d     = n_q;
    rem_req = '{start: 1'b0, dividend: x_q, divisor: bound_q};
    unique case (st_q)
      ST_IDLE: begin
        if (req_fire) begin
          bad_d = 1'b0;
          unique case (kind)
            REQ_RAW: begin
              gen_d = gen_nxt;
              val_d = gen_nxt;
              st_d  = ST_RESP;
            end
            REQ_FRACTION: begin
              gen_d = gen_nxt;
              val_d = gen_nxt >> FracShift;
              st_d  = ST_RESP;
            end
            REQ_UNIFORM: begin
              bound_d = req_i.upper_bound;
              ofs_d   = '0;
              st_d    = ST_SETUP;
            end
            REQ_RANGE: begin
              bound_d = req_i.range_high - req_i.range_low;
              ofs_d   = req_i.range_low;
              st_d    = ST_SETUP;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        if (bound_q == '0 || bound_q == '1) begin
          val_d = '0;
          bad_d = 1'b1;
          st_d  = ST_RESP;
        end else begin
          rem_req = '{start: 1'b1, dividend: '1, divisor: bound_q};
          st_d    = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (rem_done) begin
          limit_d = ~(rem + DataW'(1));
          n_d     = '0;
          st_d    = ST_DRAW;
        end
      end
      ST_DRAW: begin
        gen_d = gen_nxt;
        x_d   = gen_nxt;
        n_d   = n_q + DrawCntW'(1);
        st_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (x_q > limit_q && n_q < DrawCntW'(MaxDraws)) begin
          st_d = ST_DRAW;
        end else begin
          rem_req = '{start: 1'b1, dividend: x_q, divisor: bound_q};
          st_d    = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (rem_done) begin
          val_d = rem + ofs_q;
          st_d  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_o.ready) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (cfg_i.valid && cfg_i.ready) begin
      gen_d = cfg_i.seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      gen_q <= SeedReset;
      n_q   <= '0;
    end else begin
      st_q  <= st_d;
      gen_q <= gen_d;
      n_q   <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    ofs_q   <= ofs_d;
    limit_q <= limit_d;
    x_q     <= x_d;
    val_q   <= val_d;
    bad_q   <= bad_d;
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while a result is pending");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.bad_bound) |-> (rsp_o.value == '0))
    else $error("bad bound with nonzero value");

  a_bad_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SETUP && (bound_q == '0 || bound_q == '1) && !cfg_i.valid)
      |=> (gen_q == $past(gen_q)))
    else $error("state advanced on bad bound");

  a_rem_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (st_q == ST_LIMIT || st_q == ST_FINAL))
    else $error("remainder done outside a wait state");

endmodule

FILE: tb/xorshift64_uniform_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift64_uniform_generator_tb
// Self-checking bench for the xorshift64 uniform generator. A directed list
// covers bound extremes, bad bounds, reversed and full-width ranges and the
// zero seed. Random phases follow, each under a freshly written seed. A
// predictor tracks the generator state, including rejection redraws, and
// every result beat is checked in order against it. Both channels idle at
// random, with two long result stalls and a full drain between phases.
// ----------------------------------------------------------------------------
module xorshift64_uniform_generator_tb;
  import xsug_pkg::*;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam logic [63:0] AllOnes    = '1;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    req_kind_e          kind;
    logic [63:0]        upper_bound;
    logic signed [63:0] range_low;
    logic signed [63:0] range_high;
  } gen_req_t;

  typedef struct {
    logic [63:0] value;
    logic        bad_bound;
  } rng_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  xsug_cfg_if cfg_if ();
  xsug_req_if req_if ();
  xsug_rsp_if rsp_if ();

  xorshift64_uniform_generator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gen_req_t    pending_reqs[$];
  rng_result_t expected_results[$];
  logic [63:0] gen_state;
  int          err_cnt;
  int unsigned cycle_cnt;

  logic req_acc, rsp_acc, cfg_acc, rsp_vld_q;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] xorshift_next(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s << 21);
    t = t ^ (t >> 15);
    t = t ^ (t << 29);
    return t;
  endfunction

  task automatic draw_below_bound(input logic [63:0] bound, output logic ok,
                                  output logic [63:0] res);
    logic [63:0] accept_max;
    logic [63:0] x;
    int unsigned n;
    ok  = 1'b0;
    res = '0;
    if (bound == '0 || bound == AllOnes) return;
    accept_max = AllOnes - ((AllOnes % bound) + 64'd1);
    gen_state = xorshift_next(gen_state);
    x = gen_state;
    n = 1;
    while (x > accept_max && n < MaxDraws) begin
      gen_state = xorshift_next(gen_state);
      x = gen_state;
      n++;
    end
    res = x % bound;
    ok  = 1'b1;
  endtask

  task automatic predict_draw(input gen_req_t r, output rng_result_t o);
    logic        ok;
    logic [63:0] v;
    logic [63:0] span;
    o.value     = '0;
    o.bad_bound = 1'b0;
    case (r.kind)
      REQ_RAW: begin
        gen_state = xorshift_next(gen_state);
        o.value = gen_state;
      end
      REQ_UNIFORM: begin
        draw_below_bound(r.upper_bound, ok, v);
        if (ok) o.value = v;
        else o.bad_bound = 1'b1;
      end
      REQ_RANGE: begin
        span = r.range_high - r.range_low;
        draw_below_bound(span, ok, v);
        if (ok) o.value = v + r.range_low;
        else o.bad_bound = 1'b1;
      end
      default: begin
        gen_state = xorshift_next(gen_state);
        o.value = gen_state >> FracShift;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : monitor
    gen_req_t    beat;
    rng_result_t want;
    req_acc   <= req_if.valid && req_if.ready;
    rsp_acc   <= rsp_if.valid && rsp_if.ready;
    cfg_acc   <= cfg_if.valid && cfg_if.ready;
    rsp_vld_q <= rsp_if.valid;
    if (!rst_ni) begin
      gen_state = SeedReset;
    end else begin
      if (cfg_if.valid && cfg_if.ready) gen_state = cfg_if.seed;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat, value", rsp_if.value, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.value !== want.value)
            report_mismatch("value", rsp_if.value, want.value);
          if (rsp_if.bad_bound !== want.bad_bound)
            report_mismatch("bad_bound", 64'(rsp_if.bad_bound), 64'(want.bad_bound));
        end
      end
      if (req_if.valid && req_if.ready) begin
        beat.kind        = req_kind_e'(req_if.req_type);
        beat.upper_bound = req_if.upper_bound;
        beat.range_low   = req_if.range_low;
        beat.range_high  = req_if.range_high;
        predict_draw(beat, want);
        expected_results.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------- request driver
  bit       drv_busy;
  bit       drv_quiet;
  int       drv_gap;
  int       drv_sent;
  gen_req_t drv_cur;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drv_busy && req_acc) begin
        drv_busy = 1'b0;
        drv_sent++;
        if (drv_sent % 50 == 0) drv_quiet = ($urandom_range(0, 2) == 0);
        drv_gap = drv_quiet ? 0 : $urandom_range(0, 13);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_reqs.size() != 0) begin
          drv_cur = pending_reqs.pop_front();
          req_if.req_type    <= drv_cur.kind;
          req_if.upper_bound <= drv_cur.upper_bound;
          req_if.range_low   <= drv_cur.range_low;
          req_if.range_high  <= drv_cur.range_high;
          drv_busy = 1'b1;
        end
      end
      req_if.valid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------- result sink
  bit rsp_quiet;
  int rsp_wait;
  int rsp_seen;
  int rsp_hold;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_acc) begin
        rsp_seen++;
        if (rsp_seen % 40 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
        rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 13);
        // long stall while the sender keeps offering requests
        if (rsp_seen == 150 || rsp_seen == 900) rsp_hold = 600;
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        if (rsp_vld_q) rsp_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return 64'(1) << $urandom_range(0, 63);
      1, 2:    return 64'($urandom_range(1, 1000));
      3:       return rand64();
      4:       return (64'(1) << 63) + 64'($urandom_range(0, 5));
      5: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return AllOnes;
          2:       return 64'd1;
          default: return AllOnes - 64'd1;
        endcase
      end
      default: return rand64() >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic push_req(input req_kind_e k, input logic [63:0] ub,
                          input logic signed [63:0] lo, input logic signed [63:0] hi);
    gen_req_t r;
    r.kind        = k;
    r.upper_bound = ub;
    r.range_low   = lo;
    r.range_high  = hi;
    pending_reqs.push_back(r);
  endtask

  task automatic push_random(input int n);
    gen_req_t r;
    repeat (n) begin
      r.kind        = req_kind_e'($urandom_range(0, 3));
      r.upper_bound = rand64();
      r.range_low   = rand64();
      r.range_high  = rand64();
      if (r.kind == REQ_UNIFORM) r.upper_bound = pick_bound();
      if (r.kind == REQ_RANGE && $urandom_range(0, 3) != 0)
        r.range_high = r.range_low + pick_bound();
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || drv_busy || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_seed(input logic [63:0] s);
    wait_drained();
    cfg_if.seed  <= s;
    cfg_if.valid <= 1'b1;
    do @(negedge clk_i); while (!cfg_acc);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.seed        = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_RAW;
    req_if.upper_bound = '0;
    req_if.range_low   = '0;
    req_if.range_high  = '0;
    rsp_if.ready       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset seed, bound extremes and range corner cases
    push_req(REQ_RAW, AllOnes, -1, -1);
    push_req(REQ_FRACTION, '0, 0, 0);
    push_req(REQ_UNIFORM, '0, 0, 0);
    push_req(REQ_UNIFORM, AllOnes, 0, 0);
    push_req(REQ_UNIFORM, 64'd1, 0, 0);
    push_req(REQ_UNIFORM, 64'd2, 0, 0);
    push_req(REQ_UNIFORM, 64'd3, 0, 0);
    push_req(REQ_UNIFORM, 64'h8000_0000_0000_0000, 0, 0);
    push_req(REQ_UNIFORM, 64'h8000_0000_0000_0001, 0, 0);
    push_req(REQ_UNIFORM, AllOnes - 64'd1, 0, 0);
    push_req(REQ_UNIFORM, 64'd10, 0, 0);
    push_req(REQ_RANGE, '0, 7, 7);
    push_req(REQ_RANGE, '0, 0, -1);
    push_req(REQ_RANGE, '0, SMin, SMax);
    push_req(REQ_RANGE, '0, SMax, SMin);
    push_req(REQ_RANGE, '0, 5, -5);
    push_req(REQ_RANGE, '0, -10, 10);
    push_req(REQ_RANGE, '0, SMax - 1, SMax);
    push_req(REQ_RANGE, '0, SMin, SMin + 1000);

    // zero seed stays zero
    load_seed('0);
    push_req(REQ_RAW, '0, 0, 0);
    push_req(REQ_FRACTION, AllOnes, -1, -1);
    push_req(REQ_UNIFORM, 64'd7, 0, 0);
    push_req(REQ_UNIFORM, '0, 0, 0);
    push_req(REQ_RANGE, '0, -3, 100);
    push_req(REQ_RANGE, '0, SMax, SMin);
    push_req(REQ_UNIFORM, AllOnes - 64'd1, 0, 0);

    load_seed(AllOnes);
    push_random(300);
    load_seed(rand64());
    push_random(400);
    load_seed(64'd1);
    push_random(300);
    load_seed(64'h8000_0000_0000_0000);
    push_random(300);
    load_seed(rand64());
    push_random(300);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

endmodule
